### hw/rtl/ipf_pkg.sv
`default_nettype none

package ipf_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IPV4_ADDRESS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IPV4_PREFIX   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IPV6_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IPV6_LOW      = 3'd4;

  localparam logic [5:0] PREFIX_RESET = 6'd24;

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_V4_HOST   = 2'd1,
    MODE_V4_SUBNET = 2'd2,
    MODE_V6_HOST   = 2'd3
  } filter_mode_t;

  typedef enum logic [1:0] {
    CLASS_SHORT = 2'd0,
    CLASS_V4    = 2'd1,
    CLASS_V6    = 2'd2,
    CLASS_OTHER = 2'd3
  } frame_class_t;

  localparam logic [15:0] ETYPE_V4 = 16'h0800;
  localparam logic [15:0] ETYPE_V6 = 16'h86DD;

  // Byte offsets inside the frame
  localparam logic [15:0] POS_ETYPE_FIRST = 16'd12;
  localparam logic [15:0] POS_ETYPE_LAST  = 16'd13;
  localparam logic [15:0] POS_V6_SRC_HI   = 16'd22;
  localparam logic [15:0] POS_V4_SRC      = 16'd26;
  localparam logic [15:0] POS_V4_SRC_END  = 16'd29;
  localparam logic [15:0] POS_V4_DST      = 16'd30;
  localparam logic [15:0] POS_V4_DST_END  = 16'd33;
  localparam logic [15:0] POS_V6_SRC_END  = 16'd37;
  localparam logic [15:0] POS_V6_DST      = 16'd38;
  localparam logic [15:0] POS_V6_DST_END  = 16'd53;

  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
  localparam logic [15:0] V4_MIN_BYTES  = 16'd34;
  localparam logic [15:0] V6_MIN_BYTES  = 16'd54;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } ipf_in_t;

  typedef struct packed {
    logic         match;
    frame_class_t frame_class;
    logic [15:0]  frame_length;
  } ipf_out_t;

  typedef struct packed {
    filter_mode_t filter_mode;
    logic [31:0]  ipv4_address;
    logic [5:0]   ipv4_prefix_length;
    logic [63:0]  ipv6_address_high;
    logic [63:0]  ipv6_address_low;
  } ipf_cfg_t;

  typedef struct packed {
    logic v4_src_host;
    logic v4_dst_host;
    logic v4_src_net;
    logic v4_dst_net;
    logic v6_src_host;
    logic v6_dst_host;
  } ipf_hits_t;

  typedef struct packed {
    logic [15:0]  frame_length;
    frame_class_t frame_class;
    ipf_hits_t    hits;
  } ipf_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ipf_q_stat_t;

  // Bit i is set when i >= 32 - plen; zero prefix gives no bits, 32 and up give all.
  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [31:0] m;
    for (int i = 0; i < 32; i++) begin
      m[i] = ((7'(plen) + 7'(i)) >= 7'd32);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ipf_front.sv
`default_nettype none

module ipf_front #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ipf_pkg::ipf_in_t    in_data,
  input  wire ipf_pkg::ipf_cfg_t   cfg,
  input  wire ipf_pkg::ipf_q_stat_t q_stat,
  output logic                     push,
  output ipf_pkg::ipf_rec_t        push_rec
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

  logic [15:0]  pos;
  logic [15:0]  etype;
  logic [31:0]  v4_src;
  logic [31:0]  v4_dst;
  logic [127:0] v6_src;
  logic [127:0] v6_dst;

  logic [15:0]  etype_next;
  logic [31:0]  v4_src_next;
  logic [31:0]  v4_dst_next;
  logic [127:0] v6_src_next;
  logic [127:0] v6_dst_next;

  logic         accept;
  logic         room;
  logic [15:0]  len;
  logic [31:0]  mask;
  logic [7:0]   b;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign room     = (pos < MAX_LEN);
  assign len      = room ? (pos + 16'd1) : pos;
  assign b        = in_data.frame_byte;
  assign mask     = ipf_pkg::prefix_mask(cfg.ipv4_prefix_length);

  // Shift the byte into whichever fields own this offset
  always_comb begin
    etype_next  = etype;
    v4_src_next = v4_src;
    v4_dst_next = v4_dst;
    v6_src_next = v6_src;
    v6_dst_next = v6_dst;
    if (room) begin
      if (pos >= ipf_pkg::POS_ETYPE_FIRST && pos <= ipf_pkg::POS_ETYPE_LAST) begin
        etype_next = {etype[7:0], b};
      end
      if (pos >= ipf_pkg::POS_V4_SRC && pos <= ipf_pkg::POS_V4_SRC_END) begin
        v4_src_next = {v4_src[23:0], b};
      end
      if (pos >= ipf_pkg::POS_V4_DST && pos <= ipf_pkg::POS_V4_DST_END) begin
        v4_dst_next = {v4_dst[23:0], b};
      end
      if (pos >= ipf_pkg::POS_V6_SRC_HI && pos <= ipf_pkg::POS_V6_SRC_END) begin
        v6_src_next = {v6_src[119:0], b};
      end
      if (pos >= ipf_pkg::POS_V6_DST && pos <= ipf_pkg::POS_V6_DST_END) begin
        v6_dst_next = {v6_dst[119:0], b};
      end
    end
  end

  always_comb begin
    push_rec.frame_length = len;
    priority if (len < ipf_pkg::ETH_HDR_BYTES) begin
      push_rec.frame_class = ipf_pkg::CLASS_SHORT;
    end else if (etype_next == ipf_pkg::ETYPE_V4) begin
      push_rec.frame_class = ipf_pkg::CLASS_V4;
    end else if (etype_next == ipf_pkg::ETYPE_V6) begin
      push_rec.frame_class = ipf_pkg::CLASS_V6;
    end else begin
      push_rec.frame_class = ipf_pkg::CLASS_OTHER;
    end
    push_rec.hits.v4_src_host = (v4_src_next == cfg.ipv4_address);
    push_rec.hits.v4_dst_host = (v4_dst_next == cfg.ipv4_address);
    push_rec.hits.v4_src_net  = ((v4_src_next & mask) == (cfg.ipv4_address & mask));
    push_rec.hits.v4_dst_net  = ((v4_dst_next & mask) == (cfg.ipv4_address & mask));
    push_rec.hits.v6_src_host =
      (v6_src_next == {cfg.ipv6_address_high, cfg.ipv6_address_low});
    push_rec.hits.v6_dst_host =
      (v6_dst_next == {cfg.ipv6_address_high, cfg.ipv6_address_low});
  end

  assign push = accept && in_data.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= in_data.last_byte ? '0 : len;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      etype  <= etype_next;
      v4_src <= v4_src_next;
      v4_dst <= v4_dst_next;
      v6_src <= v6_src_next;
      v6_dst <= v6_dst_next;
    end
  end

`ifndef SYNTH
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (pos == '0))
    else $error("byte count not restarted after last byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (pos <= MAX_LEN))
    else $error("byte count beyond frame maximum");
`endif

endmodule

`default_nettype wire

### hw/rtl/ipf_fifo.sv
`default_nettype none

module ipf_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ipf_pkg::ipf_rec_t   push_rec,
  output ipf_pkg::ipf_q_stat_t     stat,
  input  wire logic                pop,
  output ipf_pkg::ipf_rec_t        pop_rec
);

  ipf_pkg::ipf_rec_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign pop_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("result queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("result queue read while empty");
`endif

endmodule

`default_nettype wire

### hw/rtl/ipf_back.sv
`default_nettype none

module ipf_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ipf_pkg::ipf_cfg_t    cfg,
  input  wire ipf_pkg::ipf_q_stat_t q_stat,
  output logic                      pop,
  input  wire ipf_pkg::ipf_rec_t    pop_rec,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ipf_pkg::ipf_out_t         out_data
);

  logic load;
  logic hit;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !q_stat.empty;

  always_comb begin
    hit = 1'b0;
    if (cfg.filter_mode == ipf_pkg::MODE_NONE) begin
      hit = 1'b1;
    end else begin
      unique case (pop_rec.frame_class)
        ipf_pkg::CLASS_V4: begin
          if (pop_rec.frame_length >= ipf_pkg::V4_MIN_BYTES) begin
            unique case (cfg.filter_mode)
              ipf_pkg::MODE_V4_HOST:
                hit = pop_rec.hits.v4_src_host || pop_rec.hits.v4_dst_host;
              ipf_pkg::MODE_V4_SUBNET:
                hit = pop_rec.hits.v4_src_net || pop_rec.hits.v4_dst_net;
              default:
                hit = 1'b0;
            endcase
          end
        end
        ipf_pkg::CLASS_V6: begin
          hit = (pop_rec.frame_length >= ipf_pkg::V6_MIN_BYTES)
             && (cfg.filter_mode == ipf_pkg::MODE_V6_HOST)
             && (pop_rec.hits.v6_src_host || pop_rec.hits.v6_dst_host);
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.match        <= hit;
      out_data.frame_class  <= pop_rec.frame_class;
      out_data.frame_length <= pop_rec.frame_length;
    end
  end

`ifndef SYNTH
  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped result not presented");
`endif

endmodule

`default_nettype wire

### hw/rtl/ethernet_ip_address_filter_top.sv
// Channel  Direction  Handshake              Payload
// in       to block   in_valid / in_stall    frame_byte, last_byte
// out      from block out_valid / out_stall  match, frame_class, frame_length
// cfg      to block   cfg_write              cfg_index, cfg_data (write only)
//
// One frame byte is taken every cycle while in_stall is low; a frame result
// passes from its last byte through the queue slot, then the output register.
// Results pass through a two-entry queue; in_stall rises only while that
// queue is full, which happens only when out_stall holds results back.
// Reset (rst, synchronous) restores register defaults and empties the queue.
`default_nettype none

module ethernet_ip_address_filter_top #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire ipf_pkg::ipf_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output ipf_pkg::ipf_out_t                      out_data,
  input  wire logic                              cfg_write,
  input  wire logic [ipf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ipf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ipf_pkg::ipf_cfg_t    cfg;
  ipf_pkg::ipf_q_stat_t q_stat;
  ipf_pkg::ipf_rec_t    push_rec;
  ipf_pkg::ipf_rec_t    pop_rec;
  logic                 push;
  logic                 pop;

  // Configuration registers; writes to unlisted indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode        <= ipf_pkg::MODE_NONE;
      cfg.ipv4_address       <= '0;
      cfg.ipv4_prefix_length <= ipf_pkg::PREFIX_RESET;
      cfg.ipv6_address_high  <= '0;
      cfg.ipv6_address_low   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ipf_pkg::REG_FILTER_MODE:
          cfg.filter_mode <= ipf_pkg::filter_mode_t'(cfg_data[1:0]);
        ipf_pkg::REG_IPV4_ADDRESS:
          cfg.ipv4_address <= cfg_data[31:0];
        ipf_pkg::REG_IPV4_PREFIX:
          cfg.ipv4_prefix_length <= cfg_data[5:0];
        ipf_pkg::REG_IPV6_HIGH:
          cfg.ipv6_address_high <= cfg_data;
        ipf_pkg::REG_IPV6_LOW:
          cfg.ipv6_address_low <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: count bytes, capture header fields, compare addresses on the last byte.
  ipf_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  // Hold finished frame records between front and back.
  ipf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .stat     (q_stat),
    .pop      (pop),
    .pop_rec  (pop_rec)
  );

  // Back: apply the filter mode and register the result request.
  ipf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_rec   (pop_rec),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
